// ----- src/tsvs_pkg.sv -----
// Package for the test stand valve sequencer: mode codes, valve bit positions,
// configuration register indexes and the structs passed between the modules.
// Has no dependencies; every other file imports it.
`default_nettype none

package tsvs_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned PRES_W  = 20;
   localparam int unsigned VALVE_W = 12;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Operating modes.
   localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FILL  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PRE   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TEST  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POST  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ABORT = 3'd5;

   // Valve bit positions.
   localparam int unsigned V_OPV104 = 0;
   localparam int unsigned V_OPV106 = 1;
   localparam int unsigned V_OPV109 = 2;
   localparam int unsigned V_OPV110 = 3;
   localparam int unsigned V_OPV118 = 4;
   localparam int unsigned V_OPV120 = 5;
   localparam int unsigned V_OPV121 = 6;
   localparam int unsigned V_FPV203 = 7;
   localparam int unsigned V_FPV204 = 8;
   localparam int unsigned V_FPV205 = 9;
   localparam int unsigned V_NMV305 = 10;
   localparam int unsigned V_NPV315 = 11;

   // Safe pattern held in abort.
   localparam logic [VALVE_W-1:0] SAFE_VALVES =
      VALVE_W'((1 << V_OPV118) | (1 << V_FPV203) | (1 << V_NPV315));

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_DELAY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_PHASE1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_PHASE2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_PHASE3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRES_TOL    = 3'd4;

   // Configuration reset values.
   localparam logic [TIME_W-1:0] FILL_DELAY_RST  = 32'd2000;
   localparam logic [TIME_W-1:0] TEST_PHASE1_RST = 32'd1000;
   localparam logic [TIME_W-1:0] TEST_PHASE2_RST = 32'd4000;
   localparam logic [TIME_W-1:0] TEST_PHASE3_RST = 32'd10000;
   localparam logic [PRES_W-1:0] PRES_TOL_RST    = 20'd500;

   typedef struct packed {
      logic [TIME_W-1:0] fill_delay_ms;
      logic [TIME_W-1:0] test_phase1_ms;
      logic [TIME_W-1:0] test_phase2_ms;
      logic [TIME_W-1:0] test_phase3_ms;
      logic [PRES_W-1:0] pressure_tolerance;
   } tsvs_cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]        now_ms;
      logic                     estop;
      logic                     telemetry_ok;
      logic                     start_fill;
      logic                     operator_clear;
      logic                     finish_fill;
      logic                     launch;
      logic                     end_test;
      logic signed [PRES_W-1:0] pressure_a;
      logic signed [PRES_W-1:0] pressure_b;
   } tsvs_item_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [TIME_W-1:0]  step_start;
      logic [VALVE_W-1:0] valves;
      logic               ignitor;
   } tsvs_state_type;

endpackage

`default_nettype wire

// ----- src/test_stand_valve_sequencer_core.sv -----
// Top level of the test stand valve sequencer: input register, configuration
// registers, sequencer state and the result register.
// Depends on tsvs_pkg and tsvs_step.
`default_nettype none

// Channel   Handshake               Payload
// req       req_valid / req_ready   one control tick (time, buttons, health, pressures)
// rsp       rsp_valid / rsp_ready   valve bits, ignitor drive and mode after the tick
// csr       csr_we                  csr_index selects the register, csr_wdata the value
//
// One transaction is accepted per cycle when the result side keeps up.
// A tick is captured in the input register and evaluated against the sequencer
// state once the result register is free; the result register then drives rsp.
// Reset clears the state to idle with all valves closed and loads the
// configuration defaults. A stalled rsp holds the result; the input register
// then holds one more tick and req_ready drops until rsp is taken.
module test_stand_valve_sequencer_core
   import tsvs_pkg::*;
(
   input  wire                            clock,
   input  wire                            reset,

   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire         [TIME_W-1:0]       req_now_ms,
   input  wire                            req_estop,
   input  wire                            req_telemetry_ok,
   input  wire                            req_start_fill,
   input  wire                            req_operator_clear,
   input  wire                            req_finish_fill,
   input  wire                            req_launch,
   input  wire                            req_end_test,
   input  wire  signed [PRES_W-1:0]       req_pressure_a,
   input  wire  signed [PRES_W-1:0]       req_pressure_b,

   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic        [VALVE_W-1:0]      rsp_valve_bits,
   output logic                           rsp_ignitor_on,
   output logic        [MODE_W-1:0]       rsp_mode,

   input  wire                            csr_we,
   input  wire         [CSR_IDX_W-1:0]    csr_index,
   input  wire         [CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers.
   tsvs_cfg_type   cfg_ff, cfg_in;

   // Input register holding one accepted tick.
   logic           item_valid_ff, item_valid_in;
   tsvs_item_type  item_ff, item_in;

   // Sequencer state carried from tick to tick.
   tsvs_state_type state_ff, state_in;
   tsvs_state_type state_next;

   // Result register.
   logic           rsp_valid_ff, rsp_valid_in;
   tsvs_state_type rsp_ff, rsp_in;

   logic           advance;

   // The held tick is evaluated when the result register is free or is being
   // emptied in this cycle.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   tsvs_step u_step (
      .cur  (state_ff),
      .item (item_ff),
      .cfg  (cfg_ff),
      .nxt  (state_next)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FILL_DELAY:  cfg_in.fill_delay_ms      = csr_wdata;
            CSR_TEST_PHASE1: cfg_in.test_phase1_ms     = csr_wdata;
            CSR_TEST_PHASE2: cfg_in.test_phase2_ms     = csr_wdata;
            CSR_TEST_PHASE3: cfg_in.test_phase3_ms     = csr_wdata;
            CSR_PRES_TOL:    cfg_in.pressure_tolerance = csr_wdata[PRES_W-1:0];
            default: begin
               // Writes to unassigned indexes are dropped.
            end
         endcase
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_ready) begin
         item_valid_in = req_valid;
         item_in       = '{now_ms:         req_now_ms,
                           estop:          req_estop,
                           telemetry_ok:   req_telemetry_ok,
                           start_fill:     req_start_fill,
                           operator_clear: req_operator_clear,
                           finish_fill:    req_finish_fill,
                           launch:         req_launch,
                           end_test:       req_end_test,
                           pressure_a:     req_pressure_a,
                           pressure_b:     req_pressure_b};
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (advance) begin
         state_in     = state_next;
         rsp_valid_in = 1'b1;
         rsp_in       = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{fill_delay_ms:      FILL_DELAY_RST,
                     test_phase1_ms:     TEST_PHASE1_RST,
                     test_phase2_ms:     TEST_PHASE2_RST,
                     test_phase3_ms:     TEST_PHASE3_RST,
                     pressure_tolerance: PRES_TOL_RST};
         state_ff <= '{mode: MODE_IDLE, step_start: '0, valves: '0, ignitor: 1'b0};
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_valve_bits = rsp_ff.valves;
   assign rsp_ignitor_on = rsp_ff.ignitor;
   assign rsp_mode       = rsp_ff.mode;

endmodule

`default_nettype wire

// ----- src/tsvs_step.sv -----
// Next-state logic of the valve sequencer: one control tick applied to the
// current mode, timer start and latches. Purely combinational.
// Depends on tsvs_pkg.
`default_nettype none

module tsvs_step
   import tsvs_pkg::*;
(
   input  tsvs_state_type cur,
   input  tsvs_item_type  item,
   input  tsvs_cfg_type   cfg,
   output tsvs_state_type nxt
);

   logic [TIME_W-1:0]       elapsed;
   logic signed [PRES_W:0]  diff;
   logic [PRES_W:0]         mag;
   logic                    fault;
   logic                    pres_ok;

   assign fault = item.estop | ~item.telemetry_ok;
   assign diff  = (PRES_W+1)'(item.pressure_a) - (PRES_W+1)'(item.pressure_b);
   assign mag   = diff[PRES_W] ? (PRES_W+1)'(-diff) : (PRES_W+1)'(diff);
   assign pres_ok = mag <= {1'b0, cfg.pressure_tolerance};

   always_comb begin
      nxt = cur;
      if (cur.mode != MODE_ABORT && fault) begin
         nxt.mode       = MODE_ABORT;
         nxt.step_start = item.now_ms;
      end
      // A restart of the fill timer takes effect before the delay is tested.
      if (nxt.mode == MODE_FILL && item.operator_clear) begin
         nxt.step_start = item.now_ms;
      end
      elapsed = item.now_ms - nxt.step_start;

      case (nxt.mode)
         MODE_IDLE: begin
            nxt.valves  = '0;
            nxt.ignitor = 1'b0;
            if (item.start_fill) begin
               nxt.mode       = MODE_FILL;
               nxt.step_start = item.now_ms;
            end
         end
         MODE_FILL: begin
            nxt.valves[V_OPV110] = 1'b0;
            if (item.operator_clear) begin
               nxt.valves[V_OPV106] = 1'b0;
               nxt.valves[V_OPV109] = 1'b1;
            end
            if (elapsed >= cfg.fill_delay_ms) begin
               nxt.valves[V_OPV104] = 1'b1;
            end
            if (item.finish_fill) begin
               nxt.valves[V_OPV104] = 1'b0;
               nxt.valves[V_OPV109] = 1'b0;
               nxt.valves[V_OPV106] = 1'b1;
               nxt.mode             = MODE_PRE;
               nxt.step_start       = item.now_ms;
            end
         end
         MODE_PRE: begin
            nxt.valves[V_OPV118] = 1'b0;
            nxt.valves[V_FPV203] = 1'b0;
            nxt.valves[V_NMV305] = 1'b1;
            nxt.valves[V_OPV121] = 1'b1;
            if (pres_ok) begin
               nxt.valves[V_OPV110] = 1'b1;
            end
            if (item.launch) begin
               nxt.valves[V_OPV110] = 1'b0;
               nxt.valves[V_FPV204] = 1'b1;
               nxt.mode             = MODE_TEST;
               nxt.step_start       = item.now_ms;
            end
         end
         MODE_TEST: begin
            nxt.ignitor = 1'b1;
            if (elapsed >= cfg.test_phase1_ms) begin
               nxt.valves[V_FPV205] = 1'b1;
               nxt.valves[V_OPV120] = 1'b1;
            end
            if (elapsed >= cfg.test_phase2_ms) begin
               nxt.valves[V_OPV120] = 1'b0;
               nxt.valves[V_FPV204] = 1'b0;
               nxt.valves[V_NMV305] = 1'b0;
               nxt.valves[V_NPV315] = 1'b1;
               nxt.valves[V_OPV118] = 1'b1;
               nxt.valves[V_FPV203] = 1'b1;
            end
            if (elapsed >= cfg.test_phase3_ms) begin
               nxt.valves[V_FPV205] = 1'b0;
            end
            if (item.end_test) begin
               nxt.ignitor    = 1'b0;
               nxt.mode       = MODE_POST;
               nxt.step_start = item.now_ms;
            end
         end
         MODE_POST: begin
            nxt.ignitor          = 1'b0;
            nxt.valves[V_OPV120] = 1'b0;
            nxt.valves[V_FPV205] = 1'b0;
            nxt.valves[V_OPV118] = 1'b1;
            nxt.valves[V_FPV203] = 1'b1;
            nxt.valves[V_NPV315] = 1'b1;
         end
         MODE_ABORT: begin
            nxt.ignitor = 1'b0;
            nxt.valves  = SAFE_VALVES;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/tsvs_checker.sv -----
// Port-level checker for the valve sequencer and its bind to the top level.
// Depends on tsvs_pkg and test_stand_valve_sequencer_core.
`default_nettype none

module tsvs_checker
   import tsvs_pkg::*;
(
   input wire                     clock,
   input wire                     reset,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input wire [VALVE_W-1:0]       rsp_valve_bits,
   input wire                     rsp_ignitor_on,
   input wire [MODE_W-1:0]        rsp_mode
);

   // Abort always shows the safe pattern with the ignitor off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == MODE_ABORT |->
         rsp_valve_bits == SAFE_VALVES && !rsp_ignitor_on)
      else $error("abort result without safe valve pattern");

   // The ignitor is only driven while testing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignitor_on |-> rsp_mode == MODE_TEST)
      else $error("ignitor on outside test");

   // Idle keeps every valve closed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == MODE_IDLE |-> rsp_valve_bits == '0)
      else $error("valve open in idle");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_valve_bits) && $stable(rsp_mode)
         && $stable(rsp_ignitor_on))
      else $error("stalled result changed");

   // No result is valid right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind test_stand_valve_sequencer_core tsvs_checker u_tsvs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_valve_bits (rsp_valve_bits),
   .rsp_ignitor_on (rsp_ignitor_on),
   .rsp_mode       (rsp_mode)
);

`default_nettype wire

// ----- test/tb_test_stand_valve_sequencer_core.sv -----
// Self-checking testbench for test_stand_valve_sequencer_core: drives control ticks
// through one pass of the mode sequence and checks every result against a predictor.
// Depends on tsvs_pkg and the RTL of the sequencer core.
module tb_test_stand_valve_sequencer_core
   import tsvs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // A tick passes only through the input and result registers, so a short pause after the
   // last expected result is enough to know the pipeline is empty.
   localparam int unsigned SETTLE_CYCLES = 8;
   // Longest legitimate quiet stretch is a long random gap or stall plus a settle
   // pause; this limit is many times that.
   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int PRES_MAX = (1 << (PRES_W - 1)) - 1;
   localparam int PRES_MIN = -PRES_MAX - 1;

   typedef struct packed {
      logic [VALVE_W-1:0] valves;
      logic               ignitor;
      logic [MODE_W-1:0]  mode;
   } valve_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_ready;
   tsvs_item_type req_tick = '{default: '0, telemetry_ok: 1'b1};

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [VALVE_W-1:0] rsp_valve_bits;
   logic               rsp_ignitor_on;
   logic [MODE_W-1:0]  rsp_mode;

   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Ticks waiting to be driven, and the results they are predicted to produce.
   tsvs_item_type     pending_ticks[$];
   valve_outcome_type expected_outcomes[$];

   // Predictor copy of the configuration and the sequencer state.
   tsvs_cfg_type sequencer_cfg = '{FILL_DELAY_RST, TEST_PHASE1_RST, TEST_PHASE2_RST,
                                   TEST_PHASE3_RST, PRES_TOL_RST};
   logic [MODE_W-1:0]  seq_mode = MODE_IDLE;
   logic [TIME_W-1:0]  seq_start = '0;
   logic [VALVE_W-1:0] seq_valves = '0;
   logic               seq_ignitor = 1'b0;

   // Stimulus side: where the generator believes the current phase timer started,
   // and the last elapsed time it picked, so that time can also creep forward.
   logic [TIME_W-1:0] gen_start = '0;
   logic [TIME_W-1:0] last_elapsed = '0;

   int unsigned feed_gap = 0;
   int unsigned feed_calm = 0;
   int unsigned rsp_stall = 0;
   int unsigned rsp_calm = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatch_count = 0;

   test_stand_valve_sequencer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_now_ms         (req_tick.now_ms),
      .req_estop          (req_tick.estop),
      .req_telemetry_ok   (req_tick.telemetry_ok),
      .req_start_fill     (req_tick.start_fill),
      .req_operator_clear (req_tick.operator_clear),
      .req_finish_fill    (req_tick.finish_fill),
      .req_launch         (req_tick.launch),
      .req_end_test       (req_tick.end_test),
      .req_pressure_a     (req_tick.pressure_a),
      .req_pressure_b     (req_tick.pressure_b),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_valve_bits     (rsp_valve_bits),
      .rsp_ignitor_on     (rsp_ignitor_on),
      .rsp_mode           (rsp_mode),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Phase timers compare the wrapped 32-bit elapsed time against a limit.
   function automatic logic timer_expired(input logic [TIME_W-1:0] now,
                                          input logic [TIME_W-1:0] limit);
      logic [TIME_W-1:0] elapsed;
      elapsed = now - seq_start;
      return elapsed >= limit;
   endfunction

   // Advances the predicted sequencer by one tick and returns what it should show.
   function automatic valve_outcome_type predict_valve_step(input tsvs_item_type tk);
      logic [VALVE_W-1:0]     v;
      logic signed [PRES_W:0] diff;
      logic [PRES_W:0]        mag;
      valve_outcome_type      res;
      v = seq_valves;
      // A fault outside abort switches to abort, and abort is evaluated in this tick.
      if (seq_mode != MODE_ABORT && (tk.estop || !tk.telemetry_ok)) begin
         seq_mode = MODE_ABORT;
         seq_start = tk.now_ms;
      end
      case (seq_mode)
         MODE_IDLE: begin
            v = '0;
            seq_ignitor = 1'b0;
            if (tk.start_fill) begin
               seq_mode = MODE_FILL;
               seq_start = tk.now_ms;
            end
         end
         MODE_FILL: begin
            v[V_OPV110] = 1'b0;
            // The operator clear restarts the timer before the delay is tested.
            if (tk.operator_clear) begin
               v[V_OPV106] = 1'b0;
               v[V_OPV109] = 1'b1;
               seq_start = tk.now_ms;
            end
            if (timer_expired(tk.now_ms, sequencer_cfg.fill_delay_ms))
               v[V_OPV104] = 1'b1;
            if (tk.finish_fill) begin
               v[V_OPV104] = 1'b0;
               v[V_OPV109] = 1'b0;
               v[V_OPV106] = 1'b1;
               seq_mode = MODE_PRE;
               seq_start = tk.now_ms;
            end
         end
         MODE_PRE: begin
            // Exact 21-bit difference, so the magnitude never overflows.
            diff = $signed({tk.pressure_a[PRES_W-1], tk.pressure_a})
                 - $signed({tk.pressure_b[PRES_W-1], tk.pressure_b});
            mag = diff[PRES_W] ? -diff : diff;
            v[V_OPV118] = 1'b0;
            v[V_FPV203] = 1'b0;
            v[V_NMV305] = 1'b1;
            v[V_OPV121] = 1'b1;
            if (mag <= {1'b0, sequencer_cfg.pressure_tolerance})
               v[V_OPV110] = 1'b1;
            if (tk.launch) begin
               v[V_OPV110] = 1'b0;
               v[V_FPV204] = 1'b1;
               seq_mode = MODE_TEST;
               seq_start = tk.now_ms;
            end
         end
         MODE_TEST: begin
            seq_ignitor = 1'b1;
            if (timer_expired(tk.now_ms, sequencer_cfg.test_phase1_ms)) begin
               v[V_FPV205] = 1'b1;
               v[V_OPV120] = 1'b1;
            end
            if (timer_expired(tk.now_ms, sequencer_cfg.test_phase2_ms)) begin
               v[V_OPV120] = 1'b0;
               v[V_FPV204] = 1'b0;
               v[V_NMV305] = 1'b0;
               v[V_NPV315] = 1'b1;
               v[V_OPV118] = 1'b1;
               v[V_FPV203] = 1'b1;
            end
            if (timer_expired(tk.now_ms, sequencer_cfg.test_phase3_ms))
               v[V_FPV205] = 1'b0;
            if (tk.end_test) begin
               seq_ignitor = 1'b0;
               seq_mode = MODE_POST;
               seq_start = tk.now_ms;
            end
         end
         MODE_POST: begin
            seq_ignitor = 1'b0;
            v[V_OPV120] = 1'b0;
            v[V_FPV205] = 1'b0;
            v[V_OPV118] = 1'b1;
            v[V_FPV203] = 1'b1;
            v[V_NPV315] = 1'b1;
         end
         MODE_ABORT: begin
            seq_ignitor = 1'b0;
            v = SAFE_VALVES;
         end
         default: ;
      endcase
      seq_valves = v;
      res.valves = seq_valves;
      res.ignitor = seq_ignitor;
      res.mode = seq_mode;
      return res;
   endfunction

   // Gap lengths for both sides: mostly none or short, a few long, and now and
   // then a long stretch with no gaps at all.
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Picks a tick time relative to the phase start: within two of one of the limits,
   // somewhere below it, anywhere at all (which covers backwards jumps), or a
   // small step on from the previous tick.
   function automatic logic [TIME_W-1:0] pick_now(input logic [TIME_W-1:0] t0, t1, t2);
      logic [TIME_W-1:0] thr;
      logic [TIME_W-1:0] el;
      case ($urandom_range(0, 2))
         0: thr = t0;
         1: thr = t1;
         default: thr = t2;
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: el = thr + TIME_W'($urandom_range(0, 4)) - TIME_W'(2);
         3, 4: el = $urandom_range(0, thr);
         5: el = $urandom();
         default: el = last_elapsed + TIME_W'($urandom_range(0, 40));
      endcase
      last_elapsed = el;
      return gen_start + el;
   endfunction

   function automatic logic signed [PRES_W-1:0] pick_pressure();
      case ($urandom_range(0, 7))
         0: return PRES_W'(PRES_MIN);
         1: return PRES_W'(PRES_MAX);
         2: return '0;
         default: return PRES_W'($urandom());
      endcase
   endfunction

   // A healthy tick with no buttons pressed.
   function automatic tsvs_item_type calm_tick(input logic [TIME_W-1:0] now);
      tsvs_item_type tk;
      tk = '0;
      tk.now_ms = now;
      tk.telemetry_ok = 1'b1;
      return tk;
   endfunction

   // Queues random ticks that keep the sequencer in its present mode: the button
   // that would leave it is held off and no fault is raised, except in abort,
   // where everything is random.
   task automatic queue_section(input int unsigned count, input logic [MODE_W-1:0] where);
      tsvs_item_type tk;
      int            pa_i;
      int            pb_i;
      int            d_i;
      for (int unsigned i = 0; i < count; i++) begin
         if (where == MODE_FILL)
            tk = calm_tick(pick_now(sequencer_cfg.fill_delay_ms, sequencer_cfg.fill_delay_ms,
                                    sequencer_cfg.fill_delay_ms));
         else
            tk = calm_tick(pick_now(sequencer_cfg.test_phase1_ms, sequencer_cfg.test_phase2_ms,
                                    sequencer_cfg.test_phase3_ms));
         tk.start_fill = $urandom_range(0, 1);
         tk.operator_clear = ($urandom_range(0, 5) == 0);
         tk.finish_fill = $urandom_range(0, 1);
         tk.launch = $urandom_range(0, 1);
         tk.end_test = $urandom_range(0, 1);
         tk.pressure_a = pick_pressure();
         tk.pressure_b = pick_pressure();
         case (where)
            MODE_IDLE: tk.start_fill = 1'b0;
            MODE_FILL: begin
               tk.finish_fill = 1'b0;
               if (tk.operator_clear)
                  gen_start = tk.now_ms;
            end
            MODE_PRE: begin
               tk.launch = 1'b0;
               // Most pairs sit right at the tolerance boundary.
               if ($urandom_range(0, 3) != 0) begin
                  pb_i = int'(tk.pressure_b);
                  d_i = int'(sequencer_cfg.pressure_tolerance) + int'($urandom_range(0, 2)) - 1;
                  if ($urandom_range(0, 1))
                     d_i = -d_i;
                  pa_i = pb_i + d_i;
                  if (pa_i >= PRES_MIN && pa_i <= PRES_MAX)
                     tk.pressure_a = PRES_W'(pa_i);
               end
            end
            MODE_TEST: tk.end_test = 1'b0;
            MODE_ABORT: begin
               tk.now_ms = $urandom();
               tk.estop = $urandom_range(0, 1);
               tk.telemetry_ok = $urandom_range(0, 1);
            end
            default: ;
         endcase
         pending_ticks.push_back(tk);
      end
   endtask

   // Waits until every queued tick has been taken and every result has come back.
   task automatic settle();
      while (pending_ticks.size() != 0 || req_valid || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Lets the block drain, then writes all five registers plus one write to an
   // unused index, which must be ignored.
   task automatic tune(input logic [CSR_DATA_W-1:0] fill, phase1, phase2, phase3, tol);
      settle();
      write_reg(CSR_FILL_DELAY, fill);
      write_reg(CSR_TEST_PHASE1, phase1);
      write_reg(CSR_TEST_PHASE2, phase2);
      write_reg(CSR_TEST_PHASE3, phase3);
      write_reg(CSR_PRES_TOL, tol);
      write_reg(CSR_PRES_TOL + CSR_IDX_W'($urandom_range(1, 3)), $urandom());
      csr_we <= 1'b0;
      sequencer_cfg.fill_delay_ms = fill;
      sequencer_cfg.test_phase1_ms = phase1;
      sequencer_cfg.test_phase2_ms = phase2;
      sequencer_cfg.test_phase3_ms = phase3;
      sequencer_cfg.pressure_tolerance = tol[PRES_W-1:0];
   endtask

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Driver. The prediction is made when a transaction is taken, from the payload
   // on the wires before this edge. A new tick is loaded only when the slot frees.
   always @(posedge clock) begin : feed_proc
      if (reset) begin
         req_valid <= 1'b0;
         feed_gap = 0;
      end else begin
         if (req_valid && req_ready)
            expected_outcomes.push_back(predict_valve_step(req_tick));
         if (!req_valid || req_ready) begin
            if (feed_gap != 0) begin
               feed_gap--;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               req_tick <= pending_ticks.pop_front();
               req_valid <= 1'b1;
               feed_gap = pick_gap(feed_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each result transaction is checked field by field against the oldest
   // prediction; stalls of random length follow taken results.
   always @(posedge clock) begin : check_proc
      valve_outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               flag_mismatch($sformatf("unexpected result valves %03h ignitor %0b mode %0d",
                                       rsp_valve_bits, rsp_ignitor_on, rsp_mode));
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_valve_bits !== want.valves)
                  flag_mismatch($sformatf("valve_bits %03h, expected %03h",
                                          rsp_valve_bits, want.valves));
               if (rsp_ignitor_on !== want.ignitor)
                  flag_mismatch($sformatf("ignitor_on %0b, expected %0b",
                                          rsp_ignitor_on, want.ignitor));
               if (rsp_mode !== want.mode)
                  flag_mismatch($sformatf("mode %0d, expected %0d", rsp_mode, want.mode));
            end
            rsp_stall = pick_gap(rsp_calm);
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any transaction on either channel means a hang.
   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Stimulus. Abort is never left and post-test only on a fault, so with one reset the run
   // walks the sequence once: idle gets many ticks under one register setting, fill, pre-test
   // and test each get many under several, before the run ends in post-test and then abort.
   initial begin : stimulus_proc
      tsvs_item_type tk;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Longest fill delay and zero pressure tolerance to start with.
      tune(32'hFFFF_FFFF, 32'd1000, 32'd4000, 32'd10000, 32'd0);
      gen_start = '0;
      queue_section(50, MODE_IDLE);

      // Idle ignores every button except start, whatever the pressures.
      tk = calm_tick(32'hFFFF_FFFF);
      tk.operator_clear = 1'b1;
      tk.finish_fill = 1'b1;
      tk.launch = 1'b1;
      tk.end_test = 1'b1;
      tk.pressure_a = PRES_W'(PRES_MIN);
      tk.pressure_b = PRES_W'(PRES_MAX);
      pending_ticks.push_back(tk);
      tk = calm_tick(32'd0);
      tk.pressure_a = PRES_W'(PRES_MAX);
      tk.pressure_b = PRES_W'(PRES_MIN);
      pending_ticks.push_back(tk);

      tk = calm_tick(32'd100);
      tk.start_fill = 1'b1;
      pending_ticks.push_back(tk);
      gen_start = tk.now_ms;

      // Fill timer: one short of the longest delay stays closed, an operator clear
      // restarts the timer, and a tick one millisecond before the new start wraps
      // around to the full delay and opens the main fill valve.
      pending_ticks.push_back(calm_tick(gen_start + 32'hFFFF_FFFE));
      tk = calm_tick(gen_start + 32'd77);
      tk.operator_clear = 1'b1;
      pending_ticks.push_back(tk);
      gen_start = tk.now_ms;
      pending_ticks.push_back(calm_tick(gen_start - 32'd1));

      tune(32'd0, 32'd1000, 32'd4000, 32'd10000, 32'd0);
      queue_section(60, MODE_FILL);
      tune(32'd2000, 32'd1000, 32'd4000, 32'd10000, 32'd0);
      queue_section(70, MODE_FILL);
      tune($urandom_range(0, 5000), 32'd1000, 32'd4000, 32'd10000, 32'd0);
      queue_section(70, MODE_FILL);

      // Finish together with a clear: the finish wins for the fill valves.
      tk = calm_tick(gen_start + $urandom_range(0, 9000));
      tk.operator_clear = 1'b1;
      tk.finish_fill = 1'b1;
      pending_ticks.push_back(tk);
      gen_start = tk.now_ms;

      // Pressure compare with zero tolerance: a difference of one either way and
      // the widest difference stay closed, equal pressures open the equalize valve.
      tk = calm_tick(gen_start + 32'd10);
      tk.pressure_a = PRES_W'(1001);
      tk.pressure_b = PRES_W'(1000);
      pending_ticks.push_back(tk);
      tk.pressure_a = PRES_W'(999);
      pending_ticks.push_back(tk);
      tk.pressure_a = PRES_W'(PRES_MAX);
      tk.pressure_b = PRES_W'(PRES_MIN);
      pending_ticks.push_back(tk);
      tk.pressure_a = PRES_W'(-3000);
      tk.pressure_b = PRES_W'(-3000);
      pending_ticks.push_back(tk);

      tune(32'd0, 32'd1000, 32'd4000, 32'd10000, 32'hFFFF_FFFF);
      queue_section(60, MODE_PRE);
      tune(32'd0, 32'd1000, 32'd4000, 32'd10000, 32'd500);
      queue_section(70, MODE_PRE);
      // Junk above bit 19 of the tolerance write must not matter.
      tune(32'd0, 32'd1000, 32'd4000, 32'd10000,
           {12'($urandom()), 20'($urandom_range(0, 3000))});
      queue_section(70, MODE_PRE);

      tune(32'd2000, 32'd1000, 32'd4000, 32'd10000, 32'd500);
      tk = calm_tick(gen_start + 32'd12345);
      tk.launch = 1'b1;
      pending_ticks.push_back(tk);
      gen_start = tk.now_ms;

      // Each test phase limit reached exactly, after one tick just short of the first.
      pending_ticks.push_back(calm_tick(gen_start + 32'd999));
      pending_ticks.push_back(calm_tick(gen_start + 32'd1000));
      pending_ticks.push_back(calm_tick(gen_start + 32'd4000));
      pending_ticks.push_back(calm_tick(gen_start + 32'd10000));
      queue_section(200, MODE_TEST);

      tune(32'd2000, 32'd0, 32'd0, 32'd0, 32'd500);
      queue_section(150, MODE_TEST);
      tune(32'd2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd500);
      queue_section(150, MODE_TEST);
      begin : ordered_phases
         logic [TIME_W-1:0] p1;
         logic [TIME_W-1:0] p2;
         logic [TIME_W-1:0] p3;
         p1 = $urandom_range(0, 3000);
         p2 = p1 + $urandom_range(0, 5000);
         p3 = p2 + $urandom_range(0, 8000);
         tune(32'd2000, p1, p2, p3, 32'd500);
      end
      queue_section(200, MODE_TEST);
      // Limits in any order, so the phases can overlap in unusual ways.
      tune(32'd2000, $urandom_range(0, 12000), $urandom_range(0, 12000),
           $urandom_range(0, 12000), 32'd500);
      queue_section(150, MODE_TEST);

      tk = calm_tick(gen_start + $urandom_range(0, 20000));
      tk.end_test = 1'b1;
      pending_ticks.push_back(tk);
      gen_start = tk.now_ms;

      tune($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      queue_section(120, MODE_POST);

      // Fault from post-test: estop, lost telemetry, or both.
      tk = calm_tick(gen_start + $urandom_range(0, 5000));
      case ($urandom_range(0, 2))
         0: tk.estop = 1'b1;
         1: tk.telemetry_ok = 1'b0;
         default: begin
            tk.estop = 1'b1;
            tk.telemetry_ok = 1'b0;
         end
      endcase
      pending_ticks.push_back(tk);
      queue_section(130, MODE_ABORT);

      settle();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
